### rtl/substring_replace_all_assert.svh
// Assertion macros used by the substring_replace_all checker.
`ifndef SUBSTRING_REPLACE_ALL_ASSERT_SVH
`define SUBSTRING_REPLACE_ALL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sra_pkg.sv
// Shared constants and types for the streaming find-and-replace block.
package sra_pkg;

  localparam int SRA_MAX_PATTERN     = 8;
  localparam int SRA_MAX_REPLACEMENT = 8;
  localparam int SRA_QUEUE_DEPTH     = 2;
  localparam int SRA_CFG_DATA_W      = 64;
  localparam int SRA_CFG_INDEX_W     = 2;
  localparam int SRA_LEN_W           = 4;

  typedef enum logic [SRA_CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES     = 2'd0,
    REG_PATTERN_LEN       = 2'd1,
    REG_REPLACEMENT_BYTES = 2'd2,
    REG_REPLACEMENT_LEN   = 2'd3
  } reg_index_t;

  // Limit a length register to a maximum.
  function automatic logic [SRA_LEN_W-1:0] clamp_len(input logic [SRA_LEN_W-1:0] len,
                                                     input logic [SRA_LEN_W-1:0] lim);
    clamp_len = (len > lim) ? lim : len;
  endfunction

endpackage

### rtl/sra_front.sv
// Front end: holds config and the match window, turns incoming items into output jobs.
module sra_front import sra_pkg::*; #(
  parameter int MAX_PATTERN     = SRA_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = SRA_MAX_REPLACEMENT,
  parameter int JOB_BYTES       = SRA_MAX_PATTERN,
  parameter int COUNT_W         = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [SRA_CFG_INDEX_W-1:0] cfg_index,
  input  logic [SRA_CFG_DATA_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  input  logic                       q_full,
  output logic                       push,
  output logic [JOB_BYTES*8-1:0]     job_bytes,
  output logic [COUNT_W-1:0]         job_count,
  output logic                       job_last
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  logic [SRA_CFG_DATA_W-1:0] pattern_bytes;
  logic [SRA_LEN_W-1:0]      pattern_len;
  logic [SRA_CFG_DATA_W-1:0] replacement_bytes;
  logic [SRA_LEN_W-1:0]      replacement_len;

  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [MAX_PATTERN-1:0][7:0] win_app;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           fill_app;
  logic [SRA_LEN_W-1:0]        p_eff;
  logic [SRA_LEN_W-1:0]        r_eff;
  logic                        hit;
  logic                        full_win;
  logic                        accept;
  logic [JOB_BYTES-1:0][7:0]   job_b;
  logic [COUNT_W-1:0]          cnt;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign p_eff     = clamp_len(pattern_len, SRA_LEN_W'(MAX_PATTERN));
  assign r_eff     = clamp_len(replacement_len, SRA_LEN_W'(MAX_REPLACEMENT));
  assign fill_app  = fill + FILL_W'(1);
  assign push      = accept && ((cnt != '0) || in_last);
  assign job_bytes = job_b;
  assign job_count = cnt;
  assign job_last  = in_last;

  // Append the new byte, compare against the pattern, build the job
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_app[i] = (FILL_W'(i) == fill) ? in_byte : window[i];
    end
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((SRA_LEN_W'(i) < p_eff) && (win_app[i] != pattern_bytes[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    full_win    = (SRA_LEN_W'(fill_app) == p_eff);
    job_b       = '0;
    cnt         = '0;
    window_next = window;
    fill_next   = fill;
    if (p_eff == '0) begin
      // pass-through
      job_b[0] = in_byte;
      cnt      = COUNT_W'(1);
    end else if (full_win && hit) begin
      // match: emit replacement, drop the whole window
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        job_b[i] = replacement_bytes[8*i +: 8];
      end
      cnt       = COUNT_W'(r_eff);
      fill_next = '0;
    end else if (full_win) begin
      // no match: emit oldest byte, or flush all at end of string
      for (int i = 0; i < MAX_PATTERN; i++) begin
        job_b[i] = win_app[i];
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        window_next[i] = win_app[i+1];
      end
      if (in_last) begin
        cnt       = COUNT_W'(p_eff);
        fill_next = '0;
      end else begin
        cnt       = COUNT_W'(1);
        fill_next = FILL_W'(p_eff - SRA_LEN_W'(1));
      end
    end else begin
      // window not yet full: hold, or flush at end of string
      for (int i = 0; i < MAX_PATTERN; i++) begin
        job_b[i] = win_app[i];
      end
      window_next = win_app;
      if (in_last) begin
        cnt       = COUNT_W'(fill_app);
        fill_next = '0;
      end else begin
        fill_next = fill_app;
      end
    end
  end

  // Config registers and window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_len       <= '0;
      replacement_bytes <= '0;
      replacement_len   <= '0;
      fill              <= '0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg_data;
          end
          REG_PATTERN_LEN: begin
            pattern_len <= cfg_data[SRA_LEN_W-1:0];
            fill        <= '0;
          end
          REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg_data;
          end
          REG_REPLACEMENT_LEN: begin
            replacement_len <= cfg_data[SRA_LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Window bytes, read only below fill
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

### rtl/sra_queue.sv
// Short job queue between the front and back ends.
module sra_queue import sra_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = SRA_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt == CNT_W'(DEPTH));
  assign head_valid = (cnt != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/sra_back.sv
// Back end: walks the head job one byte per cycle into the output register while the output is not stalled.
module sra_back import sra_pkg::*; #(
  parameter int JOB_BYTES = SRA_MAX_PATTERN,
  parameter int COUNT_W   = 4,
  parameter int IDX_W     = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  logic [JOB_BYTES*8-1:0] head_bytes,
  input  logic [COUNT_W-1:0]     head_count,
  input  logic                   head_last,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   byte_present,
  output logic                   run_end,
  output logic                   string_end
);

  logic [JOB_BYTES-1:0][7:0] bytes_arr;
  logic [IDX_W-1:0]          idx;
  logic [7:0]                sel_byte;
  logic                      has;
  logic                      is_end;
  logic                      load;

  assign bytes_arr = head_bytes;

  // Pick the current byte and see whether it closes the job
  always_comb begin
    sel_byte = bytes_arr[idx];
    has      = (head_count != '0);
    is_end   = !has || ((COUNT_W'(idx) + COUNT_W'(1)) == head_count);
    load     = head_valid && (!out_valid || out_ready);
    pop      = load && is_end;
  end

  // Output valid and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_end ? '0 : idx + IDX_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= has ? sel_byte : 8'h00;
      byte_present <= has;
      run_end      <= is_end;
      string_end   <= is_end && head_last;
    end
  end

endmodule

### rtl/substring_replace_all.sv
// Top level of the streaming find-and-replace-all block.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready  | in_byte, in_last
//   out     | output    | out_valid / out_ready| out_byte, byte_present, run_end,
//           |           |                      | string_end
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One item per cycle while each item yields at most one result; an item that
// yields several results (at most the larger of the two length limits) holds the
// output register while they go out one by one. The front end takes items into
// a two-job queue, so it keeps accepting while the output stalls until the queue
// is full. Reset is synchronous; the block is ready right after it.
module substring_replace_all import sra_pkg::*; #(
  parameter int MAX_PATTERN     = SRA_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = SRA_MAX_REPLACEMENT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [SRA_CFG_INDEX_W-1:0] cfg_index,
  input  logic [SRA_CFG_DATA_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       byte_present,
  output logic                       run_end,
  output logic                       string_end
);

  localparam int JOB_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int COUNT_W   = $clog2(JOB_BYTES + 1);
  localparam int IDX_W     = (JOB_BYTES > 1) ? $clog2(JOB_BYTES) : 1;
  localparam int JOB_W     = JOB_BYTES * 8 + COUNT_W + 1;

  logic                   q_full;
  logic                   push;
  logic [JOB_BYTES*8-1:0] job_bytes;
  logic [COUNT_W-1:0]     job_count;
  logic                   job_last;
  logic                   pop;
  logic                   head_valid;
  logic [JOB_W-1:0]       head_data;

  sra_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .JOB_BYTES       (JOB_BYTES),
    .COUNT_W         (COUNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .job_bytes (job_bytes),
    .job_count (job_count),
    .job_last  (job_last)
  );

  sra_queue #(
    .WIDTH (JOB_W),
    .DEPTH (SRA_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({job_last, job_count, job_bytes}),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  sra_back #(
    .JOB_BYTES (JOB_BYTES),
    .COUNT_W   (COUNT_W),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_bytes   (head_data[JOB_BYTES*8-1:0]),
    .head_count   (head_data[JOB_BYTES*8 +: COUNT_W]),
    .head_last    (head_data[JOB_W-1]),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .run_end      (run_end),
    .string_end   (string_end)
  );

endmodule

### rtl/sra_check.sv
// Port-level checker for substring_replace_all, bound to the top level.
`include "substring_replace_all_assert.svh"

module sra_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       run_end,
  input logic       string_end
);

  logic [10:0] out_word;
  logic        out_stall;
  logic        marker_ok;

  assign out_word  = {out_byte, byte_present, run_end, string_end};
  assign out_stall = out_valid && !out_ready;
  assign marker_ok = (out_byte == 8'h00) && run_end && string_end;

  // A stalled result holds its payload
  `SRA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

  // The end of a string also ends the item's run
  `SRA_ASSERT_NOW(a_end_in_run, out_valid && string_end, run_end, "string end without run end")

  // An end marker carries no byte and closes the string
  `SRA_ASSERT_NOW(a_marker, out_valid && !byte_present, marker_ok, "malformed end marker")

  // Nothing is shown right after reset, unless in_valid was high as reset ended
  `SRA_ASSERT_NEXT(a_reset_quiet, $fell(rst), !out_valid || $past(in_valid), "early result")

endmodule

bind substring_replace_all sra_check u_sra_check (.*);
